/* hw/rtl/rscn_pkg.sv */
package rscn_pkg;

   localparam int IN_W            = 16;
   localparam int CN0_W           = 17;
   localparam int CFG_W           = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int MAX_SAMPLE_BITS = 24;
   localparam int DB_K_W          = 26;

   // 10*log10(2) * 256 * 2^32 / 2^16
   localparam logic [DB_K_W-1:0] DB_PER_LOG2 = 26'd50504453;
   localparam logic [15:0] NSR_LIMIT       = 16'd40960;
   localparam logic [15:0] GAIN_RESET      = 16'd655;
   localparam logic [15:0] BW_RESET        = 16'd7680;
   localparam logic [15:0] INIT_CN0_RESET  = 16'd10240;

   localparam logic SEL_FIRST  = 1'b0;
   localparam logic SEL_SECOND = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AVG_GAIN     = 2'd0,
      CSR_BANDWIDTH_DB = 2'd1,
      CSR_INITIAL_CN0  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQI, ST_SQQ, ST_WACC,
      ST_DIVN_LD, ST_DIVN_RUN, ST_DIVT_LD, ST_DIVT_RUN,
      ST_GN_LD, ST_GN_RUN, ST_GT_LD, ST_GT_RUN,
      ST_CHK, ST_LN_RUN, ST_LS_LD, ST_LS_RUN,
      ST_DB_LD, ST_DB_RUN, ST_OUT_W, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_SQUARE, OP_WACC,
      OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_STORE,
      OP_MUL_GAIN, OP_MUL_DB, OP_MUL_STEP, OP_AVG_UPD,
      OP_NORM_LOAD, OP_NORM_STEP, OP_LOG_STORE, OP_DB_STORE,
      OP_NSR_HI, OP_NSR_LO, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel;
   } dp_cmd_type;

   typedef struct packed {
      logic warm_zero;
      logic warm_last;
      logic div_done;
      logic mul_done;
      logic norm_done;
      logic t_le_n;
      logic n_zero;
   } dp_status_type;

   // log2(1 + k/32) in Q16
   function automatic logic [16:0] log2_tab(input logic [5:0] k);
      logic [16:0] v;
      case (k)
         6'd0:  v = 17'd0;
         6'd1:  v = 17'd2909;
         6'd2:  v = 17'd5732;
         6'd3:  v = 17'd8473;
         6'd4:  v = 17'd11136;
         6'd5:  v = 17'd13727;
         6'd6:  v = 17'd16248;
         6'd7:  v = 17'd18704;
         6'd8:  v = 17'd21098;
         6'd9:  v = 17'd23433;
         6'd10: v = 17'd25711;
         6'd11: v = 17'd27936;
         6'd12: v = 17'd30109;
         6'd13: v = 17'd32234;
         6'd14: v = 17'd34312;
         6'd15: v = 17'd36346;
         6'd16: v = 17'd38336;
         6'd17: v = 17'd40286;
         6'd18: v = 17'd42196;
         6'd19: v = 17'd44068;
         6'd20: v = 17'd45904;
         6'd21: v = 17'd47705;
         6'd22: v = 17'd49472;
         6'd23: v = 17'd51207;
         6'd24: v = 17'd52911;
         6'd25: v = 17'd54584;
         6'd26: v = 17'd56229;
         6'd27: v = 17'd57845;
         6'd28: v = 17'd59434;
         6'd29: v = 17'd60997;
         6'd30: v = 17'd62534;
         6'd31: v = 17'd64047;
         6'd32: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

/* hw/rtl/rscn_ifs.sv */
interface rscn_req_if;
   import rscn_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  in_phase;
   logic signed [IN_W-1:0]  quadrature;
   modport source (output valid, in_phase, quadrature, input ready);
   modport sink (input valid, in_phase, quadrature, output ready);
endinterface

interface rscn_rsp_if;
   import rscn_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [CN0_W-1:0] cn0_estimate;
   logic                    warming_up;
   modport source (output valid, cn0_estimate, warming_up, input ready);
   modport sink (input valid, cn0_estimate, warming_up, output ready);
endinterface

interface rscn_csr_if;
   import rscn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rscn_ctrl.sv */
module rscn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  rscn_pkg::dp_status_type status,
   output rscn_pkg::dp_cmd_type    cmd
);
   import rscn_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SQI;
         ST_SQI:      state_in = ST_SQQ;
         ST_SQQ:      state_in = status.warm_zero ? ST_GN_LD : ST_WACC;
         ST_WACC:     state_in = status.warm_last ? ST_DIVN_LD : ST_OUT_W;
         ST_DIVN_LD:  state_in = ST_DIVN_RUN;
         ST_DIVN_RUN: if (status.div_done) state_in = ST_DIVT_LD;
         ST_DIVT_LD:  state_in = ST_DIVT_RUN;
         ST_DIVT_RUN: if (status.div_done) state_in = ST_OUT_W;
         ST_GN_LD:    state_in = ST_GN_RUN;
         ST_GN_RUN:   if (status.mul_done) state_in = ST_GT_LD;
         ST_GT_LD:    state_in = ST_GT_RUN;
         ST_GT_RUN:   if (status.mul_done) state_in = ST_CHK;
         ST_CHK:      state_in = (status.t_le_n || status.n_zero) ? ST_OUT : ST_LN_RUN;
         ST_LN_RUN:   if (status.norm_done) state_in = ST_LS_LD;
         ST_LS_LD:    state_in = ST_LS_RUN;
         ST_LS_RUN:   if (status.norm_done) state_in = ST_DB_LD;
         ST_DB_LD:    state_in = ST_DB_RUN;
         ST_DB_RUN:   if (status.mul_done) state_in = ST_OUT;
         ST_OUT_W:    if (out_free) state_in = ST_IDLE;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.sel   = SEL_FIRST;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_SQI: cmd.op = OP_SQUARE;
         ST_SQQ: begin
            cmd.op  = OP_SQUARE;
            cmd.sel = SEL_SECOND;
         end
         ST_WACC:     cmd.op = OP_WACC;
         ST_DIVN_LD:  cmd.op = OP_DIV_LOAD;
         ST_DIVN_RUN: cmd.op = status.div_done ? OP_DIV_STORE : OP_DIV_STEP;
         ST_DIVT_LD: begin
            cmd.op  = OP_DIV_LOAD;
            cmd.sel = SEL_SECOND;
         end
         ST_DIVT_RUN: begin
            cmd.op  = status.div_done ? OP_DIV_STORE : OP_DIV_STEP;
            cmd.sel = SEL_SECOND;
         end
         ST_GN_LD:  cmd.op = OP_MUL_GAIN;
         ST_GN_RUN: cmd.op = status.mul_done ? OP_AVG_UPD : OP_MUL_STEP;
         ST_GT_LD: begin
            cmd.op  = OP_MUL_GAIN;
            cmd.sel = SEL_SECOND;
         end
         ST_GT_RUN: begin
            cmd.op  = status.mul_done ? OP_AVG_UPD : OP_MUL_STEP;
            cmd.sel = SEL_SECOND;
         end
         ST_CHK: begin
            if (status.t_le_n) cmd.op = OP_NSR_HI;
            else if (status.n_zero) cmd.op = OP_NSR_LO;
            else cmd.op = OP_NORM_LOAD;
         end
         ST_LN_RUN: cmd.op = status.norm_done ? OP_LOG_STORE : OP_NORM_STEP;
         ST_LS_LD: begin
            cmd.op  = OP_NORM_LOAD;
            cmd.sel = SEL_SECOND;
         end
         ST_LS_RUN: begin
            cmd.op  = status.norm_done ? OP_LOG_STORE : OP_NORM_STEP;
            cmd.sel = SEL_SECOND;
         end
         ST_DB_LD:  cmd.op = OP_MUL_DB;
         ST_DB_RUN: cmd.op = status.mul_done ? OP_DB_STORE : OP_MUL_STEP;
         ST_OUT_W: begin
            cmd.sel = SEL_SECOND;
            if (out_free) cmd.op = OP_OUT;
         end
         ST_OUT: if (out_free) cmd.op = OP_OUT;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign rsp_valid_in = (cmd.op == OP_OUT) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/rscn_dp.sv */
module rscn_dp #(
   parameter int SAMPLE_BITS = 16,
   parameter int INIT_COUNT  = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rscn_pkg::dp_cmd_type                cmd,
   output rscn_pkg::dp_status_type             status,
   input  logic signed [rscn_pkg::IN_W-1:0]    in_phase,
   input  logic signed [rscn_pkg::IN_W-1:0]    quadrature,
   input  logic                                csr_write,
   input  logic [rscn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rscn_pkg::CFG_W-1:0]          csr_data,
   output logic signed [rscn_pkg::CN0_W-1:0]   cn0_estimate,
   output logic                                warming_up
);
   import rscn_pkg::*;

   localparam int SQ_W      = 2 * SAMPLE_BITS;
   localparam int AW        = 2 * SAMPLE_BITS + 16;
   localparam int PW        = AW + DB_K_W;
   localparam int EW        = $clog2(AW);
   localparam int LW        = EW + 17;
   localparam int DIV_STEPS = (AW + 15) / 16;
   localparam int DVW       = 16 * DIV_STEPS;
   localparam int DCW       = $clog2(DIV_STEPS + 1);
   localparam int RW        = 6;
   localparam int DV_W      = RW + 16;
   localparam int RK        = DV_W + RW;
   localparam int WL_W      = $clog2(INIT_COUNT + 1);
   localparam logic [RK:0] RECIP =
      (RK + 1)'(((64'd1 << RK) + 64'(INIT_COUNT - 1)) / 64'(INIT_COUNT));

   // configuration
   logic [15:0] gain_ff, gain_in, bw_ff, bw_in, icn0_ff, icn0_in;
   // state
   logic [AW-1:0]   noise_ff, noise_in, total_ff, total_in;
   logic [WL_W-1:0] warm_ff, warm_in;
   // working registers
   logic [SAMPLE_BITS-1:0] abs_i_ff, abs_i_in, abs_q_ff, abs_q_in;
   logic [SQ_W-1:0]        i2_ff, i2_in, q2_ff, q2_in;
   logic [DVW-1:0]         quo_ff, quo_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic [PW-1:0]          a_ff, a_in, prod_ff, prod_in;
   logic [DB_K_W-1:0]      b_ff, b_in;
   logic                   dir_ff, dir_in, neg_ff, neg_in;
   logic [AW-1:0]          norm_ff, norm_in;
   logic [EW-1:0]          exp_ff, exp_in;
   logic [LW-1:0]          log_a_ff, log_a_in, mag_ff, mag_in;
   logic signed [16:0]     nsr_ff, nsr_in;
   logic signed [CN0_W-1:0] cn0_ff, cn0_in;
   logic                   wout_ff, wout_in;

   // combinational helpers
   logic [MAX_SAMPLE_BITS-1:0] ext_i, ext_q;
   logic [SAMPLE_BITS-1:0]     s_i, s_q, sq_op;
   logic [SQ_W-1:0]            sq;
   logic [SQ_W:0]              psum;
   logic [AW-1:0]              x_n, x_t, x_sel, avg_sel, mag, gstep, upd;
   logic                       x_ge;
   logic [PW-1:0]              gain_rnd, db_rnd;
   logic [DV_W-1:0]            dv, dqn;
   logic [DV_W+RK:0]           dq_prod;
   logic [15:0]                dq;
   logic [15:0]                f;
   logic [16:0]                tab_a, tab_b;
   logic [11:0]                tab_d;
   logic [22:0]                ip_prod;
   logic [11:0]                ip;
   logic [LW-1:0]              log_cur;
   logic signed [LW:0]         dval;
   logic [PW-33:0]             db_w;
   logic [15:0]                dbm;
   logic signed [17:0]         cn0_w;

   assign ext_i = {{(MAX_SAMPLE_BITS - IN_W){1'b0}}, in_phase};
   assign ext_q = {{(MAX_SAMPLE_BITS - IN_W){1'b0}}, quadrature};
   assign s_i   = ext_i[SAMPLE_BITS-1:0];
   assign s_q   = ext_q[SAMPLE_BITS-1:0];

   assign sq_op = (cmd.sel == SEL_SECOND) ? abs_q_ff : abs_i_ff;
   assign sq    = sq_op * sq_op;
   assign psum  = {1'b0, i2_ff} + {1'b0, q2_ff};

   // exponential average
   assign x_n      = AW'(q2_ff) << 9;
   assign x_t      = AW'(psum) << 8;
   assign x_sel    = (cmd.sel == SEL_SECOND) ? x_t : x_n;
   assign avg_sel  = (cmd.sel == SEL_SECOND) ? total_ff : noise_ff;
   assign x_ge     = x_sel >= avg_sel;
   assign mag      = x_ge ? (x_sel - avg_sel) : (avg_sel - x_sel);
   assign gain_rnd = prod_ff + (PW'(1) << 15);
   assign gstep    = gain_rnd[AW+15:16];
   assign upd      = dir_ff ? (avg_sel + gstep) : (avg_sel - gstep);

   // divide by the warm-up count, 16 quotient bits a cycle by reciprocal multiply
   assign dv      = {rem_ff, quo_ff[DVW-1 -: 16]};
   assign dq_prod = {{(RK + 1){1'b0}}, dv} * {{DV_W{1'b0}}, RECIP};
   assign dq      = dq_prod[RK +: 16];
   assign dqn     = {{RW{1'b0}}, dq} * DV_W'(INIT_COUNT);

   // log2 of the normalized value
   assign f       = norm_ff[AW-2 -: 16];
   assign tab_a   = log2_tab({1'b0, f[15:11]});
   assign tab_b   = log2_tab({1'b0, f[15:11]} + 6'd1);
   assign tab_d   = 12'(tab_b - tab_a);
   assign ip_prod = tab_d * f[10:0];
   assign ip      = 12'((ip_prod + 23'd1024) >> 11);
   assign log_cur = (LW'(exp_ff) << 16) + LW'(tab_a) + LW'(ip);
   assign dval    = $signed({1'b0, log_a_ff}) - $signed({1'b0, log_cur});

   assign db_rnd = prod_ff + (PW'(1) << 31);
   assign db_w   = db_rnd[PW-1:32];
   assign dbm    = (db_w > (PW - 32)'(NSR_LIMIT)) ? NSR_LIMIT : db_w[15:0];

   assign cn0_w = {{2{bw_ff[15]}}, bw_ff} - {nsr_ff[16], nsr_ff};

   always_comb begin
      gain_in  = gain_ff;
      bw_in    = bw_ff;
      icn0_in  = icn0_ff;
      noise_in = noise_ff;
      total_in = total_ff;
      warm_in  = warm_ff;
      abs_i_in = abs_i_ff;
      abs_q_in = abs_q_ff;
      i2_in    = i2_ff;
      q2_in    = q2_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      dir_in   = dir_ff;
      neg_in   = neg_ff;
      norm_in  = norm_ff;
      exp_in   = exp_ff;
      log_a_in = log_a_ff;
      mag_in   = mag_ff;
      nsr_in   = nsr_ff;
      cn0_in   = cn0_ff;
      wout_in  = wout_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_AVG_GAIN:     gain_in = csr_data;
            CSR_BANDWIDTH_DB: bw_in   = csr_data;
            CSR_INITIAL_CN0:  icn0_in = csr_data;
            default:          gain_in = gain_ff;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            abs_i_in = s_i[SAMPLE_BITS-1] ? (~s_i + 1'b1) : s_i;
            abs_q_in = s_q[SAMPLE_BITS-1] ? (~s_q + 1'b1) : s_q;
         end
         OP_SQUARE: begin
            if (cmd.sel == SEL_SECOND) q2_in = sq;
            else i2_in = sq;
         end
         OP_WACC: begin
            noise_in = noise_ff + (AW'(q2_ff) << 8);
            total_in = total_ff + (AW'(psum) << 8);
            warm_in  = warm_ff - 1'b1;
         end
         OP_DIV_LOAD: begin
            quo_in  = DVW'((cmd.sel == SEL_SECOND) ? total_ff : (noise_ff << 1));
            rem_in  = '0;
            dcnt_in = DCW'(DIV_STEPS);
         end
         OP_DIV_STEP: begin
            rem_in  = RW'(dv - dqn);
            quo_in  = {quo_ff[DVW-17:0], dq};
            dcnt_in = dcnt_ff - 1'b1;
         end
         OP_DIV_STORE: begin
            if (cmd.sel == SEL_SECOND) total_in = quo_ff[AW-1:0];
            else noise_in = quo_ff[AW-1:0];
         end
         OP_MUL_GAIN: begin
            a_in    = PW'(mag);
            b_in    = DB_K_W'(gain_ff);
            prod_in = '0;
            dir_in  = x_ge;
         end
         OP_MUL_DB: begin
            a_in    = PW'(mag_ff);
            b_in    = DB_PER_LOG2;
            prod_in = '0;
         end
         OP_MUL_STEP: begin
            if (b_ff[0]) prod_in = prod_ff + a_ff;
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
         OP_AVG_UPD: begin
            if (cmd.sel == SEL_SECOND) total_in = upd;
            else noise_in = upd;
         end
         OP_NORM_LOAD: begin
            norm_in = (cmd.sel == SEL_SECOND) ? (total_ff - noise_ff) : noise_ff;
            exp_in  = EW'(AW - 1);
         end
         OP_NORM_STEP: begin
            norm_in = norm_ff << 1;
            exp_in  = exp_ff - 1'b1;
         end
         OP_LOG_STORE: begin
            if (cmd.sel == SEL_SECOND) begin
               neg_in = dval[LW];
               mag_in = dval[LW] ? LW'(-dval) : LW'(dval);
            end else begin
               log_a_in = log_cur;
            end
         end
         OP_DB_STORE: nsr_in = neg_ff ? -$signed({1'b0, dbm}) : $signed({1'b0, dbm});
         OP_NSR_HI:   nsr_in = $signed({1'b0, NSR_LIMIT});
         OP_NSR_LO:   nsr_in = -$signed({1'b0, NSR_LIMIT});
         OP_OUT: begin
            if (cmd.sel == SEL_SECOND) begin
               cn0_in  = {icn0_ff[15], icn0_ff};
               wout_in = 1'b1;
            end else begin
               if (cn0_w[17] != cn0_w[16]) cn0_in = cn0_w[17] ? 17'h10000 : 17'h0ffff;
               else cn0_in = cn0_w[16:0];
               wout_in = 1'b0;
            end
         end
         default: wout_in = wout_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         bw_ff    <= BW_RESET;
         icn0_ff  <= INIT_CN0_RESET;
         noise_ff <= '0;
         total_ff <= '0;
         warm_ff  <= WL_W'(INIT_COUNT);
      end else begin
         gain_ff  <= gain_in;
         bw_ff    <= bw_in;
         icn0_ff  <= icn0_in;
         noise_ff <= noise_in;
         total_ff <= total_in;
         warm_ff  <= warm_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_i_ff <= abs_i_in;
      abs_q_ff <= abs_q_in;
      i2_ff    <= i2_in;
      q2_ff    <= q2_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      prod_ff  <= prod_in;
      dir_ff   <= dir_in;
      neg_ff   <= neg_in;
      norm_ff  <= norm_in;
      exp_ff   <= exp_in;
      log_a_ff <= log_a_in;
      mag_ff   <= mag_in;
      nsr_ff   <= nsr_in;
      cn0_ff   <= cn0_in;
      wout_ff  <= wout_in;
   end

   assign status.warm_zero = (warm_ff == '0);
   assign status.warm_last = (warm_ff == WL_W'(1));
   assign status.div_done  = (dcnt_ff == '0);
   assign status.mul_done  = (b_ff == '0);
   assign status.norm_done = norm_ff[AW-1];
   assign status.t_le_n    = (total_ff <= noise_ff);
   assign status.n_zero    = (noise_ff == '0);

   assign cn0_estimate = cn0_ff;
   assign warming_up   = wout_ff;

endmodule

/* hw/rtl/rscn_cn0_estimator.sv */
// channel  modport  payload                      accepted when
// req_if   sink     in_phase, quadrature         valid && ready
// rsp_if   source   cn0_estimate, warming_up     valid && ready
// csr_if   sink     index, data                  valid (ready held high)
//
// one item at a time; a warm-up item squares and accumulates, the last one adds two
// divisions by the warm-up count (16 quotient bits a cycle)
// a tracking item uses the shift-add multiplier (one multiplier bit a cycle)
// and, unless noise is zero or total <= noise, the one-bit-a-cycle log normalizer
// synchronous reset restores the configuration registers, the means and the warm-up count
// a result waits in the output register; the next item is accepted meanwhile
module rscn_cn0_estimator #(
   parameter int SAMPLE_BITS = 16,
   parameter int INIT_COUNT  = 20
) (
   input logic       clock,
   input logic       reset,
   rscn_req_if.sink  req_if,
   rscn_rsp_if.source rsp_if,
   rscn_csr_if.sink  csr_if
);
   import rscn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_if.ready = 1'b1;

   rscn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .status    (status),
      .cmd       (cmd)
   );

   rscn_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INIT_COUNT  (INIT_COUNT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_phase     (req_if.in_phase),
      .quadrature   (req_if.quadrature),
      .csr_write    (csr_if.valid),
      .csr_index    (csr_if.index),
      .csr_data     (csr_if.data),
      .cn0_estimate (rsp_if.cn0_estimate),
      .warming_up   (rsp_if.warming_up)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("input accepted while an item is in flight");

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> (req_if.valid && req_if.ready))
      else $error("item captured without a handshake");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP) |-> !status.div_done)
      else $error("divider stepped past its last digit");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |=> rsp_if.valid)
      else $error("result loaded but not presented");

endmodule
